@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, masked while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/aes_sb_pkg.sv @@
// ---------------------------------------------------------------------------
// AES SubBytes package
// GF(2^8) arithmetic, affine constants and pipeline control types.
// ---------------------------------------------------------------------------
package aes_sb_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned HALF_W    = 64;
    localparam int unsigned LANES     = 16;
    localparam int unsigned DATA_W    = 2 * HALF_W;

    localparam logic [7:0] GF_REDUCE  = 8'h1b;
    localparam logic [7:0] AFFINE_XOR = 8'h63;

    typedef logic [7:0] gf_t;

    localparam gf_t AFFINE_COL [8] = '{
        8'h1f, 8'h3e, 8'h7c, 8'hf8, 8'hf1, 8'he3, 8'hc7, 8'h8f
    };

    // Load strobes for each pipeline stage, stage 4 is the output register
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } pipe_ctrl_t;

    function automatic gf_t gf_xtime(input gf_t v);
        gf_t r;
        r = {v[6:0], 1'b0};
        if (v[7]) begin
            r = r ^ GF_REDUCE;
        end
        return r;
    endfunction

    function automatic gf_t gf_mul(input gf_t a, input gf_t b);
        gf_t acc;
        gf_t pw;
        acc = '0;
        pw  = b;
        for (int k = 0; k < 8; k++) begin
            if (a[k]) begin
                acc = acc ^ pw;
            end
            pw = gf_xtime(pw);
        end
        return acc;
    endfunction

    function automatic gf_t gf_sq(input gf_t a);
        return gf_mul(a, a);
    endfunction

    function automatic gf_t sbox_affine(input gf_t t);
        gf_t r;
        r = AFFINE_XOR;
        for (int k = 0; k < 8; k++) begin
            if (t[k]) begin
                r = r ^ AFFINE_COL[k];
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/aes_sb_lane.sv @@
// ---------------------------------------------------------------------------
// S-box lane
// Three-stage x^254 exponentiation of one byte followed by the affine map.
// ---------------------------------------------------------------------------
module aes_sb_lane (
    input  logic                    aclk,
    input  aes_sb_pkg::pipe_ctrl_t  ctrl,
    input  aes_sb_pkg::gf_t         byte_in,
    output aes_sb_pkg::gf_t         sbox_out
);
    import aes_sb_pkg::*;

    gf_t s1_x2_reg, s1_x3_reg;
    gf_t s2_x2_reg, s2_x12_reg, s2_x15_reg;
    gf_t s3_x2_reg, s3_x252_reg;

    gf_t s1_x2_next, s1_x3_next;
    gf_t s2_x12_next, s2_x15_next;
    gf_t s3_x252_next;

    always_comb begin
        // x^2, x^3
        s1_x2_next   = gf_sq(byte_in);
        s1_x3_next   = gf_mul(s1_x2_next, byte_in);
        // x^12, x^15
        s2_x12_next  = gf_sq(gf_sq(s1_x3_reg));
        s2_x15_next  = gf_mul(s2_x12_next, s1_x3_reg);
        // x^240, x^252
        s3_x252_next = gf_mul(gf_sq(gf_sq(gf_sq(gf_sq(s2_x15_reg)))), s2_x12_reg);
        // x^254, affine
        sbox_out     = sbox_affine(gf_mul(s3_x252_reg, s3_x2_reg));
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld1) begin
            s1_x2_reg <= s1_x2_next;
            s1_x3_reg <= s1_x3_next;
        end
        if (ctrl.ld2) begin
            s2_x2_reg  <= s1_x2_reg;
            s2_x12_reg <= s2_x12_next;
            s2_x15_reg <= s2_x15_next;
        end
        if (ctrl.ld3) begin
            s3_x2_reg   <= s2_x2_reg;
            s3_x252_reg <= s3_x252_next;
        end
    end

endmodule

@@ rtl/aes_sb_merge.sv @@
// ---------------------------------------------------------------------------
// Lane merge
// Gathers the sixteen lane bytes into the registered 128-bit result.
// ---------------------------------------------------------------------------
module aes_sb_merge (
    input  logic                                aclk,
    input  aes_sb_pkg::pipe_ctrl_t              ctrl,
    input  aes_sb_pkg::gf_t                     lane_byte [aes_sb_pkg::LANES],
    output logic [aes_sb_pkg::DATA_W-1:0]       data_out
);
    import aes_sb_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            data_next[i*BYTE_W +: BYTE_W] = lane_byte[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld4) begin
            data_reg <= data_next;
        end
    end

    assign data_out = data_reg;

endmodule

@@ rtl/aes_subbytes_computed_sbox.sv @@
// ---------------------------------------------------------------------------
// AES SubBytes, computed S-box
// Sixteen byte lanes replace each state byte with its S-box value.
// ---------------------------------------------------------------------------
// One 128-bit state per cycle in and one per cycle out while the output is not
// stalled. Each transaction passes four register stages: three exponentiation
// stages in every lane and the output register, each with one GF multiply. The
// result is valid once it reaches the output register. A stalled output holds
// only the stages that are full, so the input keeps accepting while empty stages
// remain. No state survives between transactions; the zero byte maps to 0x63.
module aes_subbytes_computed_sbox (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [aes_sb_pkg::DATA_W-1:0]      s_tdata,   // block_low, block_high
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [aes_sb_pkg::DATA_W-1:0]      m_tdata    // sub_low, sub_high
);
    import aes_sb_pkg::*;

    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    logic       rdy1, rdy2, rdy3, rdy4;
    pipe_ctrl_t ctrl;
    gf_t        lane_byte [LANES];

    always_comb begin
        rdy4     = !v4_reg || m_tready;
        rdy3     = !v3_reg || rdy4;
        rdy2     = !v2_reg || rdy3;
        rdy1     = !v1_reg || rdy2;
        ctrl.ld1 = s_tvalid && rdy1;
        ctrl.ld2 = v1_reg && rdy2;
        ctrl.ld3 = v2_reg && rdy3;
        ctrl.ld4 = v3_reg && rdy4;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        aes_sb_lane u_lane (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .byte_in  (s_tdata[i*BYTE_W +: BYTE_W]),
            .sbox_out (lane_byte[i])
        );
    end

    aes_sb_merge u_merge (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .lane_byte (lane_byte),
        .data_out  (m_tdata)
    );

    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;

endmodule

@@ rtl/aes_sb_checker.sv @@
// ---------------------------------------------------------------------------
// SubBytes port checker
// Handshake and latency checks on the top-level ports.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module aes_sb_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [aes_sb_pkg::DATA_W-1:0]      s_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [aes_sb_pkg::DATA_W-1:0]      m_tdata
);
    import aes_sb_pkg::*;

    logic s_xfer;
    logic [DATA_W-1:0] s_seen;

    assign s_xfer = s_tvalid && s_tready;
    assign s_seen = s_tdata;

    `ASSERT_CLK(a_m_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "output transaction dropped while stalled")
    `ASSERT_CLK(a_m_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "output data changed while stalled")
    `ASSERT_CLK_NR(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    `ASSERT_CLK(a_ready_pass, aclk, aresetn, m_tready |-> s_tready, "input stalled while output drains")
    `ASSERT_CLK(a_latency, aclk, aresetn, (s_xfer && (s_seen == s_seen)) ##1 m_tready ##1 m_tready |-> ##2 m_tvalid, "transaction missing after three cycles")

endmodule

bind aes_subbytes_computed_sbox aes_sb_checker u_aes_sb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SubBytes testbench
// Streams 128-bit states through the computed S-box and checks every result
// against an in-bench predictor that builds each S-box value from a GF(2^8)
// inverse (x^254) and the AES affine map, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned HW        = aes_sb_pkg::HALF_W;
    localparam logic [7:0]  POLY_TAIL = 8'h1b;
    localparam logic [7:0]  AFF_CONST = 8'h63;
    localparam int          CYCLE_CAP = 400000;
    localparam int          SETTLE    = 20;

    typedef struct packed {
        logic [HW-1:0] sub_high;
        logic [HW-1:0] sub_low;
    } subst_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [aes_sb_pkg::DATA_W-1:0] s_tdata  = '0;   // block_low, block_high
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [aes_sb_pkg::DATA_W-1:0] m_tdata;         // sub_low, sub_high

    subst_t     subst_expect [$];
    bit         idle_en      = 1'b1;
    int         hold_left    = 0;
    int         err_count    = 0;
    int         blocks_sent  = 0;
    int         results_seen = 0;
    int         cycle_count  = 0;
    bit [255:0] byte_seen    = '0;

    aes_subbytes_computed_sbox u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] run;
        int         k;
        acc = 8'h00;
        run = b;
        for (k = 0; k < 8; k++) begin
            if (a[k]) begin
                acc = acc ^ run;
            end
            run = {run[6:0], 1'b0} ^ (run[7] ? POLY_TAIL : 8'h00);
        end
        return acc;
    endfunction

    // x^254 is the inverse for non-zero x and leaves zero at zero
    function automatic logic [7:0] gf_recip(input logic [7:0] x);
        logic [7:0] p;
        int         k;
        p = x;
        for (k = 0; k < 6; k++) begin
            p = gf_product(gf_product(p, p), x);
        end
        return gf_product(p, p);
    endfunction

    function automatic logic [7:0] sbox_of(input logic [7:0] x);
        logic [7:0] t;
        t = gf_recip(x);
        return t ^ {t[6:0], t[7]} ^ {t[5:0], t[7:6]} ^ {t[4:0], t[7:5]}
                 ^ {t[3:0], t[7:4]} ^ AFF_CONST;
    endfunction

    function automatic logic [HW-1:0] subst_half(input logic [HW-1:0] w);
        logic [HW-1:0] r;
        int            k;
        for (k = 0; k < 8; k++) begin
            r[8*k +: 8] = sbox_of(w[8*k +: 8]);
        end
        return r;
    endfunction

    function automatic logic [HW-1:0] skewed_word();
        logic [HW-1:0] w;
        int            k;
        w = {$urandom, $urandom};
        for (k = 0; k < 8; k++) begin
            case ($urandom_range(0, 7))
                0: w[8*k +: 8] = 8'h00;
                1: w[8*k +: 8] = 8'hff;
                default: ;
            endcase
        end
        return w;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    task automatic send_block(input logic [HW-1:0] blk_lo, input logic [HW-1:0] blk_hi);
        subst_t exp_item;
        int     gap;
        int     k;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blk_hi, blk_lo};
        do @(posedge aclk); while (!s_tready);
        exp_item.sub_low  = subst_half(blk_lo);
        exp_item.sub_high = subst_half(blk_hi);
        subst_expect.push_back(exp_item);
        blocks_sent++;
        for (k = 0; k < 8; k++) begin
            byte_seen[blk_lo[8*k +: 8]] = 1'b1;
            byte_seen[blk_hi[8*k +: 8]] = 1'b1;
        end
    endtask

    task automatic release_source();
        s_tvalid <= 1'b0;
    endtask

    task automatic test_extremes();
        send_block('0, '0);
        send_block('1, '1);
        send_block({8{8'h55}}, {8{8'h55}});
        send_block({8{8'haa}}, {8{8'haa}});
        send_block({8{8'h01}}, {8{8'h80}});
        send_block({8{8'h80}}, {8{8'h01}});
        send_block('0, '1);
        send_block('1, '0);
    endtask

    task automatic test_every_byte();
        logic [2*HW-1:0] blk;
        int              i;
        int              j;
        for (i = 0; i < 16; i++) begin
            for (j = 0; j < 16; j++) begin
                blk[8*((j + i) % 16) +: 8] = 8'(16 * i + j);
            end
            send_block(blk[HW-1:0], blk[2*HW-1:HW]);
        end
    endtask

    task automatic test_random(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            idle_en = (i % 300) < 220;
            if ($urandom_range(0, 1) == 0) begin
                send_block({$urandom, $urandom}, {$urandom, $urandom});
            end else begin
                send_block(skewed_word(), skewed_word());
            end
        end
        idle_en = 1'b1;
    endtask

    task automatic test_drain_pause(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            send_block(skewed_word(), skewed_word());
            if (i % 25 == 24) begin
                release_source();
                while (subst_expect.size() != 0) @(posedge aclk);
            end
        end
    endtask

    task automatic test_full_rate(input int count);
        int i;
        idle_en = 1'b0;
        for (i = 0; i < count; i++) begin
            send_block({$urandom, $urandom}, skewed_word());
        end
    endtask

    always @(posedge aclk) begin
        subst_t exp_item;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (subst_expect.size() == 0) begin
                flag_error($sformatf("unexpected transaction %h", m_tdata));
            end else begin
                exp_item = subst_expect.pop_front();
                if (m_tdata[HW-1:0] !== exp_item.sub_low) begin
                    flag_error($sformatf("sub_low expected %h actual %h",
                                         exp_item.sub_low, m_tdata[HW-1:0]));
                end
                if (m_tdata[2*HW-1:HW] !== exp_item.sub_high) begin
                    flag_error($sformatf("sub_high expected %h actual %h",
                                         exp_item.sub_high, m_tdata[2*HW-1:HW]));
                end
            end
        end
        if (!idle_en) begin
            hold_left = 0;
            m_tready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("[aes_subbytes_computed_sbox] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_every_byte();
        test_random(1400);
        test_drain_pause(100);
        test_full_rate(300);
        release_source();
        while (subst_expect.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        $display("sent %0d states, compared %0d results", blocks_sent, results_seen);
        $display("input byte values exercised: %0d of 256", $countones(byte_seen));
        if (err_count == 0) begin
            $display("[aes_subbytes_computed_sbox] OK");
        end else begin
            $display("[aes_subbytes_computed_sbox] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/aes_sb_pkg.sv
rtl/aes_sb_lane.sv
rtl/aes_sb_merge.sv
rtl/aes_subbytes_computed_sbox.sv
rtl/aes_sb_checker.sv
test/testbench.sv
